### rtl/sjfs_pkg.sv
// shared types and constants for the shortest-job-first scheduler
// no dependencies; used by every module in rtl/
package sjfs_pkg;

  localparam int PID_W           = 22;
  localparam int LEN_W           = 20;
  localparam int CNT_OUT_W       = 7;
  localparam int QUEUE_DEPTH_DEF = 64;

  typedef struct packed {
    logic [PID_W-1:0] caller_pid;
    logic [LEN_W-1:0] job_length;
  } req_t;

  typedef struct packed {
    logic                 denied;
    logic                 newly_queued;
    logic                 queue_overflow;
    logic                 cpu_busy;
    logic [PID_W-1:0]     holder_pid;
    logic [CNT_OUT_W-1:0] waiting_count;
  } rsp_t;

  // one waiting-queue entry
  typedef struct packed {
    logic [PID_W-1:0] pid;
    logic [LEN_W-1:0] len;
  } entry_t;

endpackage

### rtl/shortest_job_first_scheduler_top.sv
// shortest-job-first cpu scheduler, top level
// depends on sjfs_pkg, sjfs_seq (and through it sjfs_ram)
//
// usage
//   req channel: one cpu request per transfer (caller_pid, job_length),
//     taken at a rising edge with req_valid high and req_stall low
//   rsp channel: one result per request, held in an output register
//     until taken at an edge with rsp_valid high and rsp_stall low
//   requests are handled one at a time; req_stall is high from the edge
//     of acceptance until the result is loaded into the output register
//   a grant or a finish with an empty queue goes straight to the result; a
//     finish that hands the cpu to the queue head first reads the head
//     entry; a denied request first scans the waiting entries for its pid
//     and its insert position, and if it is queued, moves the entries at or
//     after that position up by one slot before the insert
//   the single read port of the queue memory sets the pace: the duplicate
//     scan and the entry move each sweep one entry a cycle
//   a new request is accepted while an older result still waits; that
//     request finishes its work and then holds until the register frees
//   reset (rst, synchronous): cpu idle, queue empty, no pending result;
//     queue memory contents are not cleared and need no clearing pass
module shortest_job_first_scheduler_top #(
  parameter int QUEUE_DEPTH = sjfs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  sjfs_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output sjfs_pkg::rsp_t rsp
);

  // output register is free when empty or being taken this cycle
  logic           slot_free;
  logic           done;
  sjfs_pkg::rsp_t res;

  assign slot_free = !rsp_valid || !rsp_stall;

  sjfs_seq #(.DEPTH(QUEUE_DEPTH)) u_seq (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req       (req),
    .req_stall (req_stall),
    .slot_free (slot_free),
    .done      (done),
    .res       (res)
  );

  // result register between the sequencer and the receiver
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (done) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  // payload only moves on a load, so a stalled result holds
  always_ff @(posedge clk) begin
    if (done) begin
      rsp <= res;
    end
  end

endmodule

### rtl/sjfs_ram.sv
// waiting-queue storage: one write port, one read port, registered read data
// depends on sjfs_pkg for the entry type
module sjfs_ram #(
  parameter int DEPTH = sjfs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  sjfs_pkg::entry_t     wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output sjfs_pkg::entry_t     rdata
);

  sjfs_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/sjfs_seq.sv
// scheduler sequencer: holder state, circular sorted queue control,
// scan / shift passes over the queue memory; depends on sjfs_pkg, sjfs_ram
module sjfs_seq #(
  parameter int DEPTH = sjfs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  sjfs_pkg::req_t req,
  output logic           req_stall,
  input  logic           slot_free,
  output logic           done,
  output sjfs_pkg::rsp_t res
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW:0]   DEPTH_S = (CW + 1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);

  typedef enum logic [2:0] {
    S_IDLE, S_EVAL, S_SCAN, S_DECIDE, S_SHIFT, S_INSERT, S_POP, S_FIN
  } state_t;

  state_t state;

  logic                      holder_valid;
  logic [sjfs_pkg::PID_W-1:0] holder_id;
  logic [sjfs_pkg::PID_W-1:0] pid;
  logic [sjfs_pkg::LEN_W-1:0] len;
  logic [AW-1:0]             head;
  logic [CW-1:0]             count;
  logic [CW-1:0]             iss;
  logic                      iss_on;
  logic                      rd_pend;
  logic [CW-1:0]             rd_idx;
  logic                      match;
  logic [CW-1:0]             pos;
  logic                      pos_found;
  logic                      denied;
  logic                      queued;
  logic                      overflow;

  logic [CW-1:0]    rd_lidx;
  logic [AW-1:0]    rd_phys;
  logic [CW-1:0]    wr_lidx;
  logic [AW-1:0]    wr_phys;
  logic             we;
  sjfs_pkg::entry_t wdata;
  sjfs_pkg::entry_t rdata;
  logic [CW+sjfs_pkg::CNT_OUT_W-1:0] cnt_ext;

  // logical queue index to memory slot, wrapping once around the ring
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] hd, input logic [CW-1:0] idx);
    logic [CW:0] s;
    s = {{(CW + 1 - AW){1'b0}}, hd} + {1'b0, idx};
    if (s >= DEPTH_S) begin
      s = s - DEPTH_S;
    end
    return s[AW-1:0];
  endfunction

  always_comb begin
    unique case (state)
      S_EVAL:  rd_lidx = '0;
      S_POP:   rd_lidx = ONE_C;
      default: rd_lidx = iss;
    endcase
    rd_phys = phys(head, rd_lidx);

    we      = 1'b0;
    wr_lidx = pos;
    wdata   = '{pid: pid, len: len};
    if (state == S_SHIFT && rd_pend) begin
      we      = 1'b1;
      wr_lidx = rd_idx + ONE_C;
      wdata   = rdata;
    end else if (state == S_INSERT) begin
      we = 1'b1;
    end
    wr_phys = phys(head, wr_lidx);
  end

  sjfs_ram #(.DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (wr_phys),
    .wdata (wdata),
    .raddr (rd_phys),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      holder_valid <= 1'b0;
      holder_id    <= '0;
      head         <= '0;
      count        <= '0;
      rd_pend      <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            pid   <= req.caller_pid;
            len   <= req.job_length;
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          queued    <= 1'b0;
          overflow  <= 1'b0;
          match     <= 1'b0;
          pos_found <= 1'b0;
          pos       <= count;
          iss       <= '0;
          rd_pend   <= 1'b0;
          if (!holder_valid || holder_id == pid) begin
            denied <= 1'b0;
            if (len == '0 && count == '0) begin
              holder_valid <= 1'b0;
              holder_id    <= '0;
              state        <= S_FIN;
            end else begin
              holder_valid <= 1'b1;
              holder_id    <= pid;
              if (len == '0) begin
                state <= S_POP;   // head slot read issued this cycle
              end else begin
                state <= S_FIN;
              end
            end
          end else begin
            denied <= 1'b1;
            state  <= S_SCAN;
          end
        end
        S_POP: begin
          holder_id <= rdata.pid;
          head      <= rd_phys;
          count     <= count - ONE_C;
          state     <= S_FIN;
        end
        S_SCAN: begin
          rd_pend <= (iss < count);
          if (iss < count) begin
            rd_idx <= iss;
            iss    <= iss + ONE_C;
          end
          if (rd_pend) begin
            if (rdata.pid == pid) begin
              match <= 1'b1;
            end
            if (!pos_found && rdata.len > len) begin
              pos       <= rd_idx;
              pos_found <= 1'b1;
            end
          end
          if (iss >= count && !rd_pend) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          priority if (match) begin
            state <= S_FIN;
          end else if (count == DEPTH_C) begin
            overflow <= 1'b1;
            state    <= S_FIN;
          end else begin
            queued <= 1'b1;
            if (pos_found) begin
              iss     <= count - ONE_C;
              iss_on  <= 1'b1;
              rd_pend <= 1'b0;
              state   <= S_SHIFT;
            end else begin
              state <= S_INSERT;
            end
          end
        end
        S_SHIFT: begin
          // tail-first move of entries at or after pos up by one slot
          if (iss_on) begin
            rd_pend <= 1'b1;
            rd_idx  <= iss;
            if (iss == pos) begin
              iss_on <= 1'b0;
            end else begin
              iss <= iss - ONE_C;
            end
          end else begin
            rd_pend <= 1'b0;
            state   <= S_INSERT;
          end
        end
        S_INSERT: begin
          count <= count + ONE_C;
          state <= S_FIN;
        end
        S_FIN: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign req_stall = (state != S_IDLE);
  assign done      = (state == S_FIN) && slot_free;
  assign cnt_ext   = {{sjfs_pkg::CNT_OUT_W{1'b0}}, count};

  always_comb begin
    res.denied         = denied;
    res.newly_queued   = queued;
    res.queue_overflow = overflow;
    res.cpu_busy       = holder_valid;
    res.holder_pid     = holder_valid ? holder_id : '0;
    res.waiting_count  = cnt_ext[sjfs_pkg::CNT_OUT_W-1:0];
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_C)
    else $error("queue count beyond depth");

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    !holder_valid |-> count == '0)
    else $error("entries waiting while cpu idle");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    count == $past(count) || count == $past(count) + ONE_C || count + ONE_C == $past(count))
    else $error("queue count moved by more than one");

  a_flags: assert property (@(posedge clk) disable iff (rst)
    done |-> !(res.newly_queued && res.queue_overflow) &&
             (!(res.newly_queued || res.queue_overflow) || res.denied))
    else $error("inconsistent result flags");

  a_back_idle: assert property (@(posedge clk) disable iff (rst)
    done |=> !req_stall)
    else $error("sequencer not idle after result");

endmodule
